// File: rtl/core/cdq_pkg.sv
// Package for the circular deque: command, status and cell-operation codes,
// the control word sent along the row of cells, and shared widths.
// Used by cdq_cell and circular_deque_top; depends on nothing else.
package cdq_pkg;

  localparam int DEPTH_DEF = 8;
  localparam int DATA_W    = 32;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int OCC_W     = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_REAR  = 2'd0,
    CMD_PUSH_FRONT = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_REAR   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD        = 2'd0,
    OP_SHIFT_RIGHT = 2'd1,
    OP_SHIFT_LEFT  = 2'd2,
    OP_WRITE_TAIL  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     pick_en;
    logic     pick_front;
  } cell_ctrl_t;

endpackage

// File: rtl/core/circular_deque_top.sv
// Top level of the circular deque: a row of DEPTH cells with the front word
// always in cell 0, the element count, the command decode and the result word.
// Depends on cdq_pkg and cdq_cell.
//
// Each accepted command word yields exactly one result word in the next cycle,
// and a new command is taken every cycle as long as the result register is
// empty or being read in the same cycle. A push at the front or a pop at the
// front shifts the whole row of cells by one place in that cycle; a push at
// the rear writes the cell just past the last element; a pop at the rear reads
// the last element through an AND-OR selection across all cells, which is the
// longest path and grows with DEPTH. There is no clearing pass after reset:
// the cells hold no reset value and only occupied cells are ever read.
module circular_deque_top #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [cdq_pkg::CMD_W-1:0]           in_cmd,
  input  logic signed [cdq_pkg::DATA_W-1:0]   in_push_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [cdq_pkg::DATA_W-1:0]   out_pop_value,
  output logic [cdq_pkg::STATUS_W-1:0]        out_status,
  output logic [cdq_pkg::OCC_W-1:0]           out_occupancy
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
  localparam logic [CW-1:0] ONE        = CW'(1);

  logic                       fire;
  logic                       full;
  logic                       empty;
  cdq_pkg::cmd_t              cmd;
  cdq_pkg::cell_ctrl_t        ctrl;
  cdq_pkg::status_t           status_nxt;
  logic [CW-1:0]              count_r;
  logic [CW-1:0]              count_nxt;
  logic [cdq_pkg::DATA_W-1:0] push_data;
  logic [cdq_pkg::DATA_W-1:0] pop_data;
  logic [cdq_pkg::DATA_W-1:0] cell_data [DEPTH];
  logic [cdq_pkg::DATA_W-1:0] cell_pick [DEPTH];

  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic [cdq_pkg::DATA_W-1:0] pop_value_r;
  cdq_pkg::status_t           status_r;
  logic [cdq_pkg::OCC_W-1:0]  occ_r;

  assign in_ready  = !out_valid_r || out_ready;
  assign fire      = in_valid && in_ready;
  assign cmd       = cdq_pkg::cmd_t'(in_cmd);
  assign full      = (count_r == FULL_COUNT);
  assign empty     = (count_r == '0);
  assign push_data = in_push_value;

  always_comb begin
    ctrl.op         = cdq_pkg::OP_HOLD;
    ctrl.pick_en    = 1'b0;
    ctrl.pick_front = 1'b0;
    status_nxt      = cdq_pkg::ST_DONE;
    count_nxt       = count_r;
    if (fire) begin
      unique case (cmd)
        cdq_pkg::CMD_PUSH_REAR: begin
          if (full) begin
            status_nxt = cdq_pkg::ST_OVERFLOW;
          end else begin
            ctrl.op   = cdq_pkg::OP_WRITE_TAIL;
            count_nxt = count_r + ONE;
          end
        end
        cdq_pkg::CMD_PUSH_FRONT: begin
          if (full) begin
            status_nxt = cdq_pkg::ST_OVERFLOW;
          end else begin
            ctrl.op   = cdq_pkg::OP_SHIFT_RIGHT;
            count_nxt = count_r + ONE;
          end
        end
        cdq_pkg::CMD_POP_FRONT: begin
          if (empty) begin
            status_nxt = cdq_pkg::ST_UNDERFLOW;
          end else begin
            ctrl.op         = cdq_pkg::OP_SHIFT_LEFT;
            ctrl.pick_en    = 1'b1;
            ctrl.pick_front = 1'b1;
            count_nxt       = count_r - ONE;
          end
        end
        cdq_pkg::CMD_POP_REAR: begin
          if (empty) begin
            status_nxt = cdq_pkg::ST_UNDERFLOW;
          end else begin
            ctrl.pick_en = 1'b1;
            count_nxt    = count_r - ONE;
          end
        end
        default: begin
          status_nxt = cdq_pkg::ST_DONE;
        end
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [cdq_pkg::DATA_W-1:0] left_data;
    logic [cdq_pkg::DATA_W-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_data = push_data;
    end else begin : g_mid_left
      assign left_data = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_mid_right
      assign right_data = cell_data[i+1];
    end

    cdq_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (count_r),
      .left_data  (left_data),
      .right_data (right_data),
      .push_data  (push_data),
      .data_o     (cell_data[i]),
      .pick_o     (cell_pick[i])
    );
  end

  always_comb begin
    pop_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      pop_data = pop_data | cell_pick[i];
    end
  end

  always_comb begin
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pop_value_r <= pop_data;
      status_r    <= status_nxt;
      occ_r       <= cdq_pkg::OCC_W'(count_nxt);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pop_value = pop_value_r;
  assign out_status    = status_r;
  assign out_occupancy = occ_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("element count exceeds depth");

  a_underflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == cdq_pkg::ST_UNDERFLOW) |->
      (pop_value_r == '0 && occ_r == '0))
    else $error("underflow result carries data or a nonzero occupancy");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !full && (cmd == cdq_pkg::CMD_PUSH_REAR || cmd == cdq_pkg::CMD_PUSH_FRONT))
      |=> (count_r == $past(count_r) + ONE))
    else $error("accepted push did not add one element");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == cdq_pkg::ST_OVERFLOW) |->
      (occ_r == cdq_pkg::OCC_W'(FULL_COUNT) && pop_value_r == '0))
    else $error("overflow result without a full deque");

endmodule

// File: rtl/core/cdq_cell.sv
// One cell of the deque row: holds one word and moves it to or from its
// neighbors as the broadcast control word says. Depends on cdq_pkg.
module cdq_cell #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF,
  parameter int IDX   = 0
) (
  input  logic                            clk,
  input  cdq_pkg::cell_ctrl_t             ctrl,
  input  logic [$clog2(DEPTH+1)-1:0]      count,
  input  logic [cdq_pkg::DATA_W-1:0]      left_data,
  input  logic [cdq_pkg::DATA_W-1:0]      right_data,
  input  logic [cdq_pkg::DATA_W-1:0]      push_data,
  output logic [cdq_pkg::DATA_W-1:0]      data_o,
  output logic [cdq_pkg::DATA_W-1:0]      pick_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] MY_IDX   = CW'(IDX);
  localparam logic [CW-1:0] TAIL_IDX = CW'(IDX + 1);

  logic [cdq_pkg::DATA_W-1:0] data_r;
  logic [cdq_pkg::DATA_W-1:0] data_nxt;
  logic                       sel;

  always_comb begin
    unique case (ctrl.op)
      cdq_pkg::OP_HOLD:        data_nxt = data_r;
      cdq_pkg::OP_SHIFT_RIGHT: data_nxt = left_data;
      cdq_pkg::OP_SHIFT_LEFT:  data_nxt = right_data;
      cdq_pkg::OP_WRITE_TAIL:  data_nxt = (count == MY_IDX) ? push_data : data_r;
      default:                 data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign sel    = ctrl.pick_en && (ctrl.pick_front ? (IDX == 0) : (count == TAIL_IDX));
  assign pick_o = sel ? data_r : '0;
  assign data_o = data_r;

endmodule

// File: tb/circular_deque_checker.sv
// Checker for the circular deque: watches both word channels, predicts every result word
// from its own ring, indices and count, and compares field by field in order.
// Depends on cdq_pkg.
`timescale 1ns / 100ps

module circular_deque_checker #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [cdq_pkg::CMD_W-1:0]         in_cmd,
  input  logic signed [cdq_pkg::DATA_W-1:0] in_push_value,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [cdq_pkg::DATA_W-1:0] out_pop_value,
  input  logic [cdq_pkg::STATUS_W-1:0]      out_status,
  input  logic [cdq_pkg::OCC_W-1:0]         out_occupancy,
  output int                                fail_count,
  output int                                pending
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef struct packed {
    logic signed [cdq_pkg::DATA_W-1:0] pop_value;
    cdq_pkg::status_t                  status;
    logic [cdq_pkg::OCC_W-1:0]         occupancy;
  } deque_result_t;

  logic [cdq_pkg::DATA_W-1:0] ring_words [DEPTH];
  logic [IDX_W-1:0]           head_idx;
  logic [IDX_W-1:0]           tail_idx;
  logic [CNT_W-1:0]           held;
  deque_result_t              awaited_q [$];
  deque_result_t              oldest;

  function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
  endfunction

  function automatic deque_result_t deque_apply(input cdq_pkg::cmd_t c,
                                                input logic [cdq_pkg::DATA_W-1:0] v);
    deque_result_t r;
    r.pop_value = '0;
    r.status    = cdq_pkg::ST_DONE;
    case (c)
      cdq_pkg::CMD_PUSH_REAR, cdq_pkg::CMD_PUSH_FRONT: begin
        if (held == DEPTH) begin
          r.status = cdq_pkg::ST_OVERFLOW;
        end else begin
          if (held == 0) begin
            head_idx      = '0;
            tail_idx      = '0;
            ring_words[0] = v;
          end else if (c == cdq_pkg::CMD_PUSH_REAR) begin
            tail_idx             = step_up(tail_idx);
            ring_words[tail_idx] = v;
          end else begin
            head_idx             = step_down(head_idx);
            ring_words[head_idx] = v;
          end
          held = held + 1'b1;
        end
      end
      default: begin
        if (held == 0) begin
          r.status = cdq_pkg::ST_UNDERFLOW;
        end else begin
          if (c == cdq_pkg::CMD_POP_FRONT) begin
            r.pop_value = ring_words[head_idx];
            head_idx    = step_up(head_idx);
          end else begin
            r.pop_value = ring_words[tail_idx];
            tail_idx    = step_down(tail_idx);
          end
          held = held - 1'b1;
          if (held == 0) begin
            head_idx = '0;
            tail_idx = '0;
          end
        end
      end
    endcase
    r.occupancy = cdq_pkg::OCC_W'(held);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      head_idx = '0;
      tail_idx = '0;
      held     = '0;
      awaited_q.delete();
      pending  = 0;
    end else begin
      if (in_valid && in_ready) begin
        awaited_q.push_back(deque_apply(cdq_pkg::cmd_t'(in_cmd), in_push_value));
      end
      if (out_valid && out_ready) begin
        if (awaited_q.size() == 0) begin
          $error("result word with no command outstanding");
          fail_count++;
        end else begin
          oldest = awaited_q.pop_front();
          if (out_pop_value !== oldest.pop_value) begin
            $error("pop_value: expected %0d, got %0d", oldest.pop_value, out_pop_value);
            fail_count++;
          end
          if (out_status !== oldest.status) begin
            $error("status: expected %0d, got %0d", oldest.status, out_status);
            fail_count++;
          end
          if (out_occupancy !== oldest.occupancy) begin
            $error("occupancy: expected %0d, got %0d", oldest.occupancy, out_occupancy);
            fail_count++;
          end
        end
      end
      pending = awaited_q.size();
    end
  end

endmodule

// File: tb/circular_deque_top_test.sv
// Top of the circular deque testbench: clock, reset, command stimulus and the result
// receiver, with the checker beside the block. Depends on cdq_pkg, circular_deque_top
// and circular_deque_checker.
`timescale 1ns / 100ps

module circular_deque_top_test;

  localparam int DEPTH  = cdq_pkg::DEPTH_DEF;
  localparam int DATA_W = cdq_pkg::DATA_W;

  logic                              clk;
  logic                              rst_n         = 1'b0;
  logic                              in_valid      = 1'b0;
  logic                              in_ready;
  logic [cdq_pkg::CMD_W-1:0]         in_cmd        = '0;
  logic signed [DATA_W-1:0]          in_push_value = '0;
  logic                              out_valid;
  logic                              out_ready     = 1'b0;
  logic signed [DATA_W-1:0]          out_pop_value;
  logic [cdq_pkg::STATUS_W-1:0]      out_status;
  logic [cdq_pkg::OCC_W-1:0]         out_occupancy;
  int                                fail_count;
  int                                pending;
  int                                hold_cycles   = 0;
  bit                                rush          = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  circular_deque_top #(.DEPTH(DEPTH)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_push_value (in_push_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pop_value (out_pop_value),
    .out_status    (out_status),
    .out_occupancy (out_occupancy)
  );

  circular_deque_checker #(.DEPTH(DEPTH)) deque_watch (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_push_value (in_push_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pop_value (out_pop_value),
    .out_status    (out_status),
    .out_occupancy (out_occupancy),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return {1'b0, {(DATA_W-1){1'b1}}};
      3:       return {1'b1, {(DATA_W-1){1'b0}}};
      default: return $urandom();
    endcase
  endfunction

  function automatic int draw_gap();
    return rush ? 0 : $urandom_range(0, 3);
  endfunction

  task automatic send_word(input cdq_pkg::cmd_t c, input logic [DATA_W-1:0] v);
    int gap;
    bit took;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= c;
    in_push_value <= v;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic run_receiver();
    int wait_len;
    bit took;
    forever begin
      wait_len = draw_gap();
      if (hold_cycles > 0) begin
        wait_len    = hold_cycles;
        hold_cycles = 0;
      end
      if (wait_len > 0) begin
        out_ready <= 1'b0;
        repeat (wait_len) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        took = out_valid;
        @(posedge clk);
      end while (!took);
    end
  endtask

  task automatic run_directed();
    send_word(cdq_pkg::CMD_POP_FRONT, pick_value());
    send_word(cdq_pkg::CMD_POP_REAR, pick_value());
    send_word(cdq_pkg::CMD_PUSH_FRONT, {1'b1, {(DATA_W-1){1'b0}}});
    send_word(cdq_pkg::CMD_POP_REAR, '0);
    send_word(cdq_pkg::CMD_PUSH_REAR, {1'b0, {(DATA_W-1){1'b1}}});
    send_word(cdq_pkg::CMD_PUSH_FRONT, '1);
    send_word(cdq_pkg::CMD_POP_FRONT, '1);
    send_word(cdq_pkg::CMD_POP_FRONT, $urandom());
    for (int i = 0; i < DEPTH; i++) begin
      send_word((i % 2 == 1) ? cdq_pkg::CMD_PUSH_FRONT : cdq_pkg::CMD_PUSH_REAR,
                pick_value());
    end
    send_word(cdq_pkg::CMD_PUSH_REAR, pick_value());
    send_word(cdq_pkg::CMD_PUSH_FRONT, pick_value());
    for (int i = 0; i < DEPTH; i++) begin
      send_word((i % 2 == 1) ? cdq_pkg::CMD_POP_FRONT : cdq_pkg::CMD_POP_REAR,
                $urandom());
    end
    send_word(cdq_pkg::CMD_POP_FRONT, $urandom());
  endtask

  task automatic run_random();
    int            push_pct;
    cdq_pkg::cmd_t c;
    for (int phase = 0; phase < 16; phase++) begin
      case (phase % 4)
        0:       push_pct = 85;
        1:       push_pct = 50;
        2:       push_pct = 15;
        default: push_pct = $urandom_range(30, 70);
      endcase
      rush = (phase % 5 == 2);
      if (phase == 3 || phase == 11) begin
        hold_cycles = 60;
      end
      if (phase == 7) begin
        wait_drained();
      end
      for (int k = 0; k < 100; k++) begin
        if ($urandom_range(1, 100) <= push_pct) begin
          c = $urandom_range(0, 1) ? cdq_pkg::CMD_PUSH_FRONT : cdq_pkg::CMD_PUSH_REAR;
        end else begin
          c = $urandom_range(0, 1) ? cdq_pkg::CMD_POP_FRONT : cdq_pkg::CMD_POP_REAR;
        end
        send_word(c, pick_value());
      end
    end
    rush = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    fork
      run_receiver();
    join_none
    run_directed();
    run_random();
    wait_drained();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
